// File: sv/sbh_pkg.sv
`default_nettype none
package sbh_pkg;

   localparam int SBH_ROUNDS = 12;
   localparam int BLK_BITS   = 512;
   localparam int WORD_BITS  = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PAD,
      ST_PAD_WAIT,
      ST_N_WAIT,
      ST_S_WAIT,
      ST_OUT
   } sbh_state_type;

   // compression engine status
   typedef struct packed {
      logic busy;
      logic done;
   } cmp_stat_type;

   localparam logic [7:0] SBOX [256] = '{
      252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
      233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
      249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
      5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
      235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
      181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
      21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
      50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
      223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
      224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
      167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
      173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
      7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
      225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
      32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
      89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
   };

   localparam logic [63:0] AMAT [64] = '{
      64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
      64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
      64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
      64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
      64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
      64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
      64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
      64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
      64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
      64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
      64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
      64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
      64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
      64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
   };

   // round constants, word 0 least significant
   localparam logic [63:0] RC_TAB [12][8] = '{
      '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
        64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
      '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
        64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
      '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
        64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
      '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
        64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
      '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
        64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
      '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
        64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
      '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
        64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
      '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
        64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
      '{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
        64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
      '{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
        64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
      '{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
        64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
      '{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
        64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
   };

   // linear layer: GF(2) matrix times one 64-bit row
   function automatic logic [63:0] lin_map(input logic [63:0] v);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < 64; k++) begin
         if (v[63-k]) begin
            r = r ^ AMAT[k];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/sbh_req_if.sv
`default_nettype none
interface sbh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  byte_count;
   logic        last_word;

   modport source (output valid, message_word, byte_count, last_word, input ready);
   modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface
`default_nettype wire

// File: sv/sbh_rsp_if.sv
`default_nettype none
interface sbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic        digest_last;

   modport source (output valid, digest_word, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

// File: sv/streebog_hash_core.sv
`default_nettype none
// Streebog (GOST R 34.11-2012) hash core, 512- or 256-bit digest picked by
// csr_wr_data when csr_wr_en is pulsed (a write also restarts the message).
// Message bytes arrive eight to a request, first byte in bits 7:0; by rule only
// the last request may carry fewer, which the core does not enforce. A request
// that does not complete a 64-byte block is taken while the core is idle; one that
// completes it holds the input while the compression runs 25 LPS steps on the
// single shared LPS unit. The last request then costs the pad block plus two
// finalization compressions, after which the digest leaves as 8 words
// (or the upper 4) least significant first, and the core re-initializes.
module streebog_hash_core
   import sbh_pkg::*;
#(
   parameter int ROUNDS = SBH_ROUNDS
) (
   input  wire logic clock,
   input  wire logic reset,
   sbh_req_if.sink   req_ch,
   sbh_rsp_if.source rsp_ch,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);

   sbh_state_type       state_ff, state_in;
   logic                short_ff, short_in;
   logic [BLK_BITS-1:0] chain_ff, chain_in;
   logic [BLK_BITS-1:0] n_ff, n_in;
   logic [BLK_BITS-1:0] sum_ff, sum_in;
   logic [BLK_BITS-1:0] blk_ff, blk_in;
   logic [5:0]          fill_ff, fill_in;
   logic [63:0]         pend_ff, pend_in;
   logic [2:0]          pend_cnt_ff, pend_cnt_in;
   logic                last_ff, last_in;
   logic [9:0]          inc_ff, inc_in;
   logic [2:0]          add_cnt_ff, add_cnt_in;
   logic                add_run_ff, add_run_in;
   logic                cs_ff, cs_in, cn_ff, cn_in;
   logic [2:0]          oidx_ff, oidx_in;

   logic                cmp_start;
   logic [BLK_BITS-1:0] cmp_h, cmp_n, cmp_m, cmp_hout;
   cmp_stat_type        cmp_st;

   logic [3:0]          cnt;
   logic [6:0]          total;
   logic [3:0]          first_n;
   logic [BLK_BITS-1:0] ins_blk, pad_blk, lo_blk, iv;
   logic [64:0]         s_add, n_add;
   logic [63:0]         n_addend;

   sbh_compress #(.ROUNDS(ROUNDS)) u_cmp (
      .clock (clock),
      .reset (reset),
      .start (cmp_start),
      .h_in  (cmp_h),
      .n_in  (cmp_n),
      .m_in  (cmp_m),
      .stat  (cmp_st),
      .h_out (cmp_hout)
   );

   assign iv    = short_ff ? {64{8'h01}} : '0;
   assign cnt   = (req_ch.byte_count > 4'd8) ? 4'd8 : req_ch.byte_count;
   assign total = {1'b0, fill_ff} + {3'b0, cnt};
   assign first_n = 4'(7'd64 - {1'b0, fill_ff});

   // byte merge of the request, pad block and carried-over bytes
   always_comb begin
      logic [6:0] off;
      ins_blk = blk_ff;
      pad_blk = blk_ff;
      lo_blk  = blk_ff;
      for (int b = 0; b < 64; b++) begin
         off = 7'(b) - {1'b0, fill_ff};
         if ((7'(b) >= {1'b0, fill_ff}) && (off < {3'b0, cnt})) begin
            ins_blk[8*b +: 8] = req_ch.message_word[8*off[2:0] +: 8];
         end
         if (6'(b) == fill_ff) begin
            pad_blk[8*b +: 8] = 8'h01;
         end else if (6'(b) > fill_ff) begin
            pad_blk[8*b +: 8] = 8'h00;
         end
      end
      for (int b = 0; b < 8; b++) begin
         if (3'(b) < pend_cnt_ff) begin
            lo_blk[8*b +: 8] = pend_ff[8*b +: 8];
         end
      end
   end

   // word-serial 512-bit adders for the counter and the block sum
   assign n_addend = (add_cnt_ff == 3'd0) ? {54'b0, inc_ff} : 64'd0;
   assign s_add    = {1'b0, sum_ff[63:0]} + {1'b0, blk_ff[63:0]} + {64'b0, cs_ff};
   assign n_add    = {1'b0, n_ff[63:0]} + {1'b0, n_addend} + {64'b0, cn_ff};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      short_in    = short_ff;
      chain_in    = chain_ff;
      n_in        = n_ff;
      sum_in      = sum_ff;
      blk_in      = blk_ff;
      fill_in     = fill_ff;
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      last_in     = last_ff;
      inc_in      = inc_ff;
      add_cnt_in  = add_cnt_ff;
      add_run_in  = add_run_ff;
      cs_in       = cs_ff;
      cn_in       = cn_ff;
      oidx_in     = oidx_ff;
      cmp_start   = 1'b0;
      cmp_h       = chain_ff;
      cmp_n       = n_ff;
      cmp_m       = blk_ff;
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_ch.valid = (state_ff == ST_OUT);

      if (add_run_ff) begin
         sum_in     = {s_add[63:0], sum_ff[BLK_BITS-1:64]};
         n_in       = {n_add[63:0], n_ff[BLK_BITS-1:64]};
         blk_in     = {blk_ff[63:0], blk_ff[BLK_BITS-1:64]};
         cs_in      = s_add[64];
         cn_in      = n_add[64];
         add_cnt_in = add_cnt_ff + 1'b1;
         if (add_cnt_ff == 3'd7) begin
            add_run_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               blk_in  = ins_blk;
               last_in = req_ch.last_word;
               if (total[6]) begin
                  pend_in     = req_ch.message_word >> {first_n, 3'b000};
                  pend_cnt_in = total[2:0];
                  inc_in      = 10'd512;
                  cmp_start   = 1'b1;
                  cmp_m       = ins_blk;
                  add_run_in  = 1'b1;
                  add_cnt_in  = '0;
                  cs_in       = 1'b0;
                  cn_in       = 1'b0;
                  state_in    = ST_ABSORB;
               end else begin
                  fill_in = total[5:0];
                  if (req_ch.last_word) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_ABSORB: begin
            if (cmp_st.done) begin
               chain_in = cmp_hout;
               blk_in   = lo_blk;
               fill_in  = {3'b0, pend_cnt_ff};
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            blk_in     = pad_blk;
            cmp_start  = 1'b1;
            cmp_m      = pad_blk;
            inc_in     = {1'b0, fill_ff, 3'b000};
            add_run_in = 1'b1;
            add_cnt_in = '0;
            cs_in      = 1'b0;
            cn_in      = 1'b0;
            state_in   = ST_PAD_WAIT;
         end
         ST_PAD_WAIT: begin
            if (cmp_st.done) begin
               chain_in  = cmp_hout;
               cmp_start = 1'b1;
               cmp_h     = cmp_hout;
               cmp_n     = '0;
               cmp_m     = n_ff;
               state_in  = ST_N_WAIT;
            end
         end
         ST_N_WAIT: begin
            if (cmp_st.done) begin
               chain_in  = cmp_hout;
               cmp_start = 1'b1;
               cmp_h     = cmp_hout;
               cmp_n     = '0;
               cmp_m     = sum_ff;
               state_in  = ST_S_WAIT;
            end
         end
         ST_S_WAIT: begin
            if (cmp_st.done) begin
               chain_in = cmp_hout;
               oidx_in  = short_ff ? 3'd4 : 3'd0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  chain_in = iv;
                  n_in     = '0;
                  sum_in   = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // mode write restarts the message with the new IV
      if (csr_wr_en) begin
         short_in   = csr_wr_data;
         chain_in   = csr_wr_data ? {64{8'h01}} : '0;
         n_in       = '0;
         sum_in     = '0;
         fill_in    = '0;
         add_run_in = 1'b0;
         state_in   = ST_IDLE;
      end
   end

   assign rsp_ch.digest_word = chain_ff[{oidx_ff, 6'b0} +: 64];
   assign rsp_ch.digest_last = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         short_ff   <= 1'b0;
         chain_ff   <= '0;
         n_ff       <= '0;
         sum_ff     <= '0;
         fill_ff    <= '0;
         add_run_ff <= 1'b0;
         add_cnt_ff <= '0;
         oidx_ff    <= '0;
         last_ff    <= 1'b0;
         pend_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         short_ff   <= short_in;
         chain_ff   <= chain_in;
         n_ff       <= n_in;
         sum_ff     <= sum_in;
         fill_ff    <= fill_in;
         add_run_ff <= add_run_in;
         add_cnt_ff <= add_cnt_in;
         oidx_ff    <= oidx_in;
         last_ff    <= last_in;
         pend_cnt_ff <= pend_cnt_in;
      end
      blk_ff  <= blk_in;
      pend_ff <= pend_in;
      inc_ff  <= inc_in;
      cs_ff   <= cs_in;
      cn_ff   <= cn_in;
   end

`ifndef SYNTH
   // a compression is never restarted while one is running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmp_start |-> !cmp_st.busy)
      else $error("compression started while busy");

   // the word-serial adders finish before the compression does
   a_add_first: assert property (@(posedge clock) disable iff (reset)
      cmp_st.done |-> !add_run_ff)
      else $error("counter/sum add still running at compression end");

   // no request is taken while a digest is pending
   a_out_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken during digest output");
`endif

endmodule
`default_nettype wire

// File: sv/sbh_lps.sv
`default_nettype none
module sbh_lps
   import sbh_pkg::*;
(
   input  wire logic [BLK_BITS-1:0] lps_in,
   output logic      [BLK_BITS-1:0] lps_out
);

   // S, P and L: output row i gathers byte i of every input word
   always_comb begin
      logic [63:0] v;
      lps_out = '0;
      for (int i = 0; i < 8; i++) begin
         v = '0;
         for (int j = 0; j < 8; j++) begin
            v[8*j +: 8] = SBOX[lps_in[64*j + 8*i +: 8]];
         end
         lps_out[64*i +: 64] = lin_map(v);
      end
   end

endmodule
`default_nettype wire

// File: sv/sbh_compress.sv
`default_nettype none
module sbh_compress
   import sbh_pkg::*;
#(
   parameter int ROUNDS = SBH_ROUNDS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [BLK_BITS-1:0] h_in,
   input  wire logic [BLK_BITS-1:0] n_in,
   input  wire logic [BLK_BITS-1:0] m_in,
   output cmp_stat_type             stat,
   output logic      [BLK_BITS-1:0] h_out
);

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   logic [BLK_BITS-1:0] h_ff, m_ff, key_ff, st_ff;
   logic [BLK_BITS-1:0] h_in_r, m_in_r, key_in, st_in;
   logic [RW-1:0]       rnd_ff, rnd_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic                first_ff, first_in, ph_ff, ph_in;
   logic [BLK_BITS-1:0] unit_in, unit_out;
   logic [BLK_BITS-1:0] rc_word;

   sbh_lps u_lps (.lps_in(unit_in), .lps_out(unit_out));

   // round constant of the current round
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rc_word[64*i +: 64] = RC_TAB[rnd_ff][i];
      end
   end

   // operand select for the shared LPS unit
   always_comb begin
      priority if (first_ff) begin
         unit_in = key_ff;
      end else if (ph_ff) begin
         unit_in = st_ff ^ key_ff;
      end else begin
         unit_in = key_ff ^ rc_word;
      end
   end

   // step sequencer: key schedule and state alternate on one unit
   always_comb begin
      h_in_r   = h_ff;
      m_in_r   = m_ff;
      key_in   = key_ff;
      st_in    = st_ff;
      rnd_in   = rnd_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      ph_in    = ph_ff;
      done_in  = 1'b0;
      if (start) begin
         h_in_r   = h_in;
         m_in_r   = m_in;
         key_in   = h_in ^ n_in;
         st_in    = m_in;
         rnd_in   = '0;
         busy_in  = 1'b1;
         first_in = 1'b1;
         ph_in    = 1'b1;
      end else if (busy_ff) begin
         priority if (first_ff) begin
            key_in   = unit_out;
            first_in = 1'b0;
         end else if (ph_ff) begin
            st_in = unit_out;
            ph_in = 1'b0;
         end else begin
            key_in = unit_out;
            ph_in  = 1'b1;
            if (rnd_ff == RW'(ROUNDS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         first_ff <= 1'b0;
         ph_ff    <= 1'b0;
         rnd_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         first_ff <= first_in;
         ph_ff    <= ph_in;
         rnd_ff   <= rnd_in;
      end
      h_ff   <= h_in_r;
      m_ff   <= m_in_r;
      key_ff <= key_in;
      st_ff  <= st_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign h_out     = h_ff ^ st_ff ^ key_ff ^ m_ff;

endmodule
`default_nettype wire

// File: tb/sv/streebog_hash_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module streebog_hash_core_tb;
   import sbh_pkg::*;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
      logic        cfg_wr;
      logic        cfg_val;
   } request_type;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } digest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   sbh_req_if req_ch ();
   sbh_rsp_if rsp_ch ();

   streebog_hash_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch.sink),
      .rsp_ch     (rsp_ch.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // handshakes seen at the rising edge, used by the falling-edge drivers
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      rsp_fire <= !reset && rsp_ch.valid && rsp_ch.ready;
   end

   // predictor state
   logic [63:0] hash_h [8];
   logic [63:0] hash_n [8];
   logic [63:0] hash_sum [8];
   logic [63:0] hash_blk [8];
   int unsigned hash_fill;
   logic        hash_short;

   request_type pending_reqs[$];
   digest_type  digest_queue[$];
   int errors = 0;
   int mismatches = 0;
   int digests_seen = 0;
   int messages_sent = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit drain_hold = 1'b0;

   function automatic logic [63:0] perm_sub(input logic [63:0] s[8], input int i);
      logic [63:0] v;
      v = '0;
      for (int j = 0; j < 8; j++) begin
         v[8*j +: 8] = SBOX[s[j][8*i +: 8]];
      end
      return v;
   endfunction

   function automatic logic [63:0] mix_row(input logic [63:0] v);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < 64; k++) begin
         if (v[63-k]) begin
            r ^= AMAT[k];
         end
      end
      return r;
   endfunction

   task automatic lps_step(inout logic [63:0] s[8]);
      logic [63:0] t[8];
      for (int i = 0; i < 8; i++) begin
         t[i] = mix_row(perm_sub(s, i));
      end
      s = t;
   endtask

   task automatic compress_g(inout logic [63:0] h[8], input logic [63:0] n[8],
                             input logic [63:0] m[8]);
      logic [63:0] k[8];
      logic [63:0] st[8];
      for (int i = 0; i < 8; i++) begin
         k[i] = h[i] ^ n[i];
         st[i] = m[i];
      end
      lps_step(k);
      for (int r = 0; r < 12; r++) begin
         for (int i = 0; i < 8; i++) st[i] ^= k[i];
         lps_step(st);
         for (int i = 0; i < 8; i++) k[i] ^= RC_TAB[r][i];
         lps_step(k);
      end
      for (int i = 0; i < 8; i++) h[i] ^= st[i] ^ k[i] ^ m[i];
   endtask

   task automatic add_512(inout logic [63:0] a[8], input logic [63:0] b[8]);
      logic [64:0] s;
      logic        c;
      c = 1'b0;
      for (int i = 0; i < 8; i++) begin
         s = {1'b0, a[i]} + {1'b0, b[i]} + {64'b0, c};
         a[i] = s[63:0];
         c = s[64];
      end
   endtask

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) begin
         hash_h[i] = hash_short ? 64'h0101010101010101 : 64'h0;
         hash_n[i] = '0;
         hash_sum[i] = '0;
      end
      hash_fill = 0;
   endtask

   // absorb one request, queue expected digest words on the last one
   task automatic hash_absorb(input request_type rq);
      logic [63:0] inc[8];
      logic [63:0] zero[8];
      int cnt;
      int first;
      cnt = (rq.nbytes > 8) ? 8 : rq.nbytes;
      for (int i = 0; i < 8; i++) begin
         inc[i] = '0;
         zero[i] = '0;
      end
      inc[0] = 64'd512;
      for (int i = 0; i < cnt; i++) begin
         hash_blk[hash_fill/8][8*(hash_fill%8) +: 8] = rq.word[8*i +: 8];
         hash_fill++;
         if (hash_fill >= 64) begin
            compress_g(hash_h, hash_n, hash_blk);
            add_512(hash_n, inc);
            add_512(hash_sum, hash_blk);
            hash_fill = 0;
         end
      end
      if (rq.last) begin
         hash_blk[hash_fill/8][8*(hash_fill%8) +: 8] = 8'h01;
         for (int p = hash_fill + 1; p < 64; p++) hash_blk[p/8][8*(p%8) +: 8] = 8'h00;
         inc[0] = 64'(hash_fill * 8);
         compress_g(hash_h, hash_n, hash_blk);
         add_512(hash_n, inc);
         add_512(hash_sum, hash_blk);
         compress_g(hash_h, zero, hash_n);
         compress_g(hash_h, zero, hash_sum);
         first = hash_short ? 4 : 0;
         for (int i = first; i < 8; i++) begin
            digest_queue.push_back('{word: hash_h[i], last: (i == 7)});
         end
         hash_restart();
      end
   endtask

   // driver: config writes go out only when idle
   int   send_gap = 0;
   logic have_item = 1'b0;
   request_type cur;
   int   settle = 0;

   always @(negedge clock) begin
      logic cfg_now;
      cfg_now = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            hash_absorb(cur);
            have_item = 1'b0;
         end
         if (!have_item) begin
            if (settle > 0) begin
               settle--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !(drain_hold && digest_queue.size() > 0))
            begin
               if (pending_reqs[0].cfg_wr) begin
                  if (digest_queue.size() == 0) begin
                     cur = pending_reqs.pop_front();
                     cfg_now = 1'b1;
                     csr_wr_data <= cur.cfg_val;
                     hash_short = cur.cfg_val;
                     hash_restart();
                     settle = 2;
                  end
                  req_ch.valid <= 1'b0;
               end else if (send_gap > 0) begin
                  send_gap--;
                  req_ch.valid <= 1'b0;
               end else begin
                  cur = pending_reqs.pop_front();
                  have_item = 1'b1;
                  send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                  req_ch.valid <= 1'b1;
                  req_ch.message_word <= cur.word;
                  req_ch.byte_count <= cur.nbytes;
                  req_ch.last_word <= cur.last;
               end
            end else begin
               req_ch.valid <= 1'b0;
               if (pending_reqs.size() == 0) stim_done = 1'b1;
            end
         end
      end
      csr_wr_en <= cfg_now;
   end

   // receiver stall
   int recv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_fire) begin
         recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         rsp_ch.ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ch.ready <= (recv_gap == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      digest_type exp_d;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected digest word: exp none got %h/%b",
                           rsp_ch.digest_word, rsp_ch.digest_last);
            end else begin
               exp_d = digest_queue.pop_front();
               if (exp_d.word !== rsp_ch.digest_word || exp_d.last !== rsp_ch.digest_last) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: exp %h/%b got %h/%b", exp_d.word, exp_d.last,
                              rsp_ch.digest_word, rsp_ch.digest_last);
               end
            end
         end
      end
   end

   task automatic push_word(input logic [63:0] w, input logic [3:0] n, input logic l);
      request_type r;
      r = '{word: w, nbytes: n, last: l, cfg_wr: 1'b0, cfg_val: 1'b0};
      pending_reqs.push_back(r);
      if (l) messages_sent++;
   endtask

   task automatic push_cfg(input logic v);
      pending_reqs.push_back('{word: '0, nbytes: '0, last: 1'b0, cfg_wr: 1'b1, cfg_val: v});
   endtask

   task automatic push_message(input int nwords);
      for (int i = 0; i < nwords - 1; i++) begin
         push_word({$urandom, $urandom}, ($urandom_range(0, 9) == 0) ?
                   4'($urandom_range(0, 15)) : 4'd8, 1'b0);
      end
      push_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
   endtask

   initial begin
      int count;
      req_ch.valid = 1'b0;
      req_ch.message_word = '0;
      req_ch.byte_count = '0;
      req_ch.last_word = 1'b0;
      rsp_ch.ready = 1'b0;
      hash_short = 1'b0;
      for (int i = 0; i < 8; i++) hash_blk[i] = '0;
      hash_restart();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, extremes, full block, oversized count, both modes
      push_word('0, 4'd0, 1'b1);
      push_word('1, 4'd8, 1'b1);
      push_word(64'h0706050403020100, 4'd15, 1'b1);
      for (int i = 0; i < 8; i++) push_word('1, 4'd8, (i == 7));
      push_word(64'h1122334455667788, 4'd3, 1'b0);
      push_word(64'hffeeddccbbaa9988, 4'd5, 1'b1);
      push_cfg(1'b1);
      push_word('0, 4'd0, 1'b1);
      push_word(64'h0123456789abcdef, 4'd7, 1'b1);
      push_word('1, 4'd9, 1'b0);
      push_word('1, 4'd8, 1'b0);
      push_cfg(1'b0);
      push_word('0, 4'd1, 1'b1);

      // random messages, switching mode between phases
      count = 0;
      while (count < 155) begin
         int nw;
         nw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 9);
         if ($urandom_range(0, 7) == 0) push_cfg(1'($urandom_range(0, 1)));
         push_message(nw);
         count += nw;
      end
      push_cfg(1'b1);
      push_message(3);
   end

   // pause sender once mid-run until all digests are in
   initial begin
      wait (messages_sent > 10);
      repeat (200) @(posedge clock);
      drain_hold = 1'b1;
      repeat (400) @(posedge clock);
      drain_hold = 1'b0;
   end

   initial begin
      wait (!reset);
      fork
         begin
            wait (stim_done && !have_item && digest_queue.size() == 0);
            repeat (200) @(posedge clock);
         end
         begin
            wait (idle_cycles >= 5000);
         end
      join_any
      $display("%0d messages hashed in both digest modes, %0d digest words checked",
               messages_sent, digests_seen);
      if (idle_cycles >= 5000) begin
         $display("watchdog timeout");
         $display("streebog_hash_core regression: fail");
      end else if (errors == 0 && digest_queue.size() == 0) begin
         $display("streebog_hash_core regression: pass");
      end else begin
         $display("%0d errors, %0d digest words missing", errors, digest_queue.size());
         $display("streebog_hash_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
sv/sbh_pkg.sv
sv/sbh_req_if.sv
sv/sbh_rsp_if.sv
sv/sbh_lps.sv
sv/sbh_compress.sv
sv/streebog_hash_core.sv
tb/sv/streebog_hash_core_tb.sv
